// File: design/rmap_pkg.sv
// rmap_pkg: widths, constants and shared types for the RSSI moving-average block.
// No dependencies; every other design file except rmap_chk refers to it by scoped names.
package rmap_pkg;

  // Window length. Must stay a power of two: the average is a right shift.
  localparam int SAMPLE_COUNT = 16;
  localparam int AVG_SHIFT    = $clog2(SAMPLE_COUNT);

  localparam int RAW_W    = 8;
  localparam int LEVEL_W  = 9;
  localparam int SAMPLE_W = 11;
  localparam int SUM_W    = SAMPLE_W + AVG_SHIFT;
  localparam int AVG_W    = 11;
  localparam int PCT_W    = 7;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Raw byte to level mapping
  localparam logic [RAW_W-1:0]   RAW_SPLIT   = 8'd128;
  localparam logic [LEVEL_W-1:0] HIGH_OFFSET = 9'd82;
  localparam logic [LEVEL_W-1:0] LOW_OFFSET  = 9'd65;

  // Percent scale: avg * 100 / 1023
  localparam int PROD_W   = 17;
  localparam int FULL_SCALE_W = 10;
  localparam logic [FULL_SCALE_W:0] FULL_SCALE = 11'd1023;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [SAMPLE_W-1:0]       sample_t;
  typedef logic [SUM_W-1:0]          sum_t;

  // Control and data from the top level into the window
  typedef struct packed {
    logic    shift;
    sample_t sample;
  } win_req_t;

endpackage

// File: design/rmap_level.sv
// rmap_level: maps one raw RSSI byte to a signed level and a clamped window sample.
// Pure combinational logic; depends on rmap_pkg.
module rmap_level (
  input  logic [rmap_pkg::RAW_W-1:0] raw,
  output rmap_pkg::level_t           level,
  output rmap_pkg::sample_t          sample
);

  logic [12:0] prod;
  logic [7:0]  scaled;

  // raw * 18 as two shifted copies
  assign prod   = {1'b0, raw, 4'b0} + {4'b0, raw, 1'b0};
  assign scaled = prod[12:5];

  always_comb begin
    if (raw >= rmap_pkg::RAW_SPLIT) begin
      level = rmap_pkg::level_t'({1'b0, scaled} - rmap_pkg::HIGH_OFFSET);
    end else begin
      level = rmap_pkg::level_t'({1'b0, scaled} + rmap_pkg::LOW_OFFSET);
    end
  end

  // Negative levels enter the window as zero
  assign sample = level[rmap_pkg::LEVEL_W-1] ? '0 : {level[7:0], 3'b000};

endmodule

// File: design/rmap_window.sv
// rmap_window: sliding window of samples as a shift line, plus the running sum.
// Depends on rmap_pkg.
module rmap_window (
  input  logic               clk,
  input  logic               rst_n,
  input  rmap_pkg::win_req_t req,
  output rmap_pkg::sum_t     sum_nxt
);

  rmap_pkg::sample_t taps_r [rmap_pkg::SAMPLE_COUNT];
  rmap_pkg::sum_t    sum_r;

  // The last tap is the oldest sample, the one that drops out
  assign sum_nxt = sum_r - rmap_pkg::SUM_W'(taps_r[rmap_pkg::SAMPLE_COUNT-1])
                 + rmap_pkg::SUM_W'(req.sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < rmap_pkg::SAMPLE_COUNT; i++) begin
        taps_r[i] <= '0;
      end
    end else if (req.shift) begin
      sum_r     <= sum_nxt;
      taps_r[0] <= req.sample;
      for (int i = 1; i < rmap_pkg::SAMPLE_COUNT; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
    end
  end

endmodule

// File: design/rmap_pct.sv
// rmap_pct: average * 100 / 1023, truncated, by shift-add and one correction step.
// Pure combinational logic; depends on rmap_pkg.
module rmap_pct (
  input  logic [rmap_pkg::AVG_W-1:0] avg,
  output logic [rmap_pkg::PCT_W-1:0] pct
);

  logic [rmap_pkg::PROD_W-1:0]         prod;
  logic [rmap_pkg::PCT_W-1:0]          q0;
  logic [rmap_pkg::FULL_SCALE_W:0]     rem;

  // avg * 100 = avg*64 + avg*32 + avg*4
  assign prod = {avg, 6'b0} + {1'b0, avg, 5'b0} + {4'b0, avg, 2'b0};

  // x/1024 undershoots x/1023 by at most one; remainder x - q0*1023 < 2*1023
  assign q0  = prod[rmap_pkg::PROD_W-1:rmap_pkg::FULL_SCALE_W];
  assign rem = {1'b0, prod[rmap_pkg::FULL_SCALE_W-1:0]}
             + (rmap_pkg::FULL_SCALE_W+1)'(q0);

  assign pct = (rem >= rmap_pkg::FULL_SCALE) ? q0 + 1'b1 : q0;

endmodule

// File: design/rssi_moving_average_percent.sv
// Sliding-window RSSI average: input register, level mapping, window sum,
// percent scaling and result register. Depends on rmap_pkg and the rmap_* modules.
//
// Usage:
//   Input channel in_*: one raw RSSI byte per transaction in in_tdata[7:0].
//   Result channel out_*: one result per input, in input order, packed as
//   level_dbm [8:0] (signed), average_level [19:9], percent [26:20].
//   An accepted input is held in the input register, then in the result register.
//   One item per cycle is sustained while out_tready stays high; the limit is the
//   single path from the input register through the window sum update and percent
//   scaling into the result register. The window is a 16-tap shift line with a
//   running sum; the first 15 averages include the zero samples it starts with.
//   Reset (rst_n low, synchronous) empties both pipeline registers and clears
//   the window and sum.
//   When out_tready is low a finished result holds in the result register and
//   one more item can still be taken into the input register; after that
//   in_tready drops until the result is taken.
module rssi_moving_average_percent (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rmap_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] raw_rssi
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rmap_pkg::OUT_TDATA_W-1:0]   out_tdata   // [8:0] level_dbm,
                                                         // [19:9] average_level,
                                                         // [26:20] percent, rest 0
);

  logic                        in_v_r;
  logic [rmap_pkg::RAW_W-1:0]  raw_r;
  logic                        out_free;
  logic                        advance;

  rmap_pkg::level_t            level;
  rmap_pkg::sample_t           sample;
  rmap_pkg::win_req_t          win_req;
  rmap_pkg::sum_t              sum_nxt;
  logic [rmap_pkg::AVG_W-1:0]  avg;
  logic [rmap_pkg::PCT_W-1:0]  pct;

  logic                        out_v_r;
  rmap_pkg::level_t            level_r;
  logic [rmap_pkg::AVG_W-1:0]  avg_r;
  logic [rmap_pkg::PCT_W-1:0]  pct_r;

  assign out_free  = !out_v_r || out_tready;
  assign advance   = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      raw_r <= in_tdata[rmap_pkg::RAW_W-1:0];
    end
  end

  rmap_level u_level (
    .raw    (raw_r),
    .level  (level),
    .sample (sample)
  );

  assign win_req.shift  = advance;
  assign win_req.sample = sample;

  rmap_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (win_req),
    .sum_nxt (sum_nxt)
  );

  assign avg = sum_nxt[rmap_pkg::AVG_SHIFT +: rmap_pkg::AVG_W];

  rmap_pct u_pct (
    .avg (avg),
    .pct (pct)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level_r <= level;
      avg_r   <= avg;
      pct_r   <= pct;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, pct_r, avg_r, level_r};

endmodule

// File: design/rmap_chk.sv
// rmap_chk: port-level checks on the RSSI moving-average block, bound to the top level.
// Depends on rmap_pkg widths only through the top level's ports.
module rmap_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic [17:0] scaled_avg;
  logic [17:0] pct_lo;
  logic [17:0] pct_hi;

  assign scaled_avg = 18'(out_tdata[19:9]) * 18'd100;
  assign pct_lo     = 18'(out_tdata[26:20]) * 18'd1023;
  assign pct_hi     = pct_lo + 18'd1023;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A waiting input transaction stays offered with the same data
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input dropped or changed while waiting");

  // Input side only backs up when the result side is stalled
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // Percent field agrees with the average field
  a_pct_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pct_lo <= scaled_avg && scaled_avg < pct_hi)
    else $error("percent does not match average");

  // Level and average stay in their ranges; the unused top bits are zero
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[19:9] <= 11'd1088 && out_tdata[31:27] == 5'd0
      && ($signed(out_tdata[8:0]) >= -9'sd10) && ($signed(out_tdata[8:0]) <= 9'sd136))
    else $error("result field out of range");

endmodule

bind rssi_moving_average_percent rmap_chk u_rmap_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/sv/rssi_moving_average_percent_test.sv
// Self-checking testbench for rssi_moving_average_percent: directed and random
// raw RSSI bytes under varying stream back-pressure, checked by a window predictor.
// Depends on rmap_pkg and the rssi_moving_average_percent design files.
module rssi_moving_average_percent_test;

  localparam int RAW_SPLIT_V  = 128;
  localparam int LEVEL_MULT   = 18;
  localparam int LEVEL_SHIFT  = 5;
  localparam int HIGH_OFS     = 82;
  localparam int LOW_OFS      = 65;
  localparam int SAMPLE_SHIFT = 3;
  localparam int PCT_SCALE    = 100;
  localparam int FULL_RANGE   = 1023;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    rmap_pkg::level_t           level_dbm;
    logic [rmap_pkg::AVG_W-1:0] average_level;
    logic [rmap_pkg::PCT_W-1:0] percent;
  } rssi_result_t;

  class rssi_window_scoreboard;
    int unsigned  taps[rmap_pkg::SAMPLE_COUNT];
    int unsigned  slot;
    int unsigned  running_sum;
    rssi_result_t pending_results[$];
    int           errors;

    function new();
      foreach (taps[i]) taps[i] = 0;
      slot = 0;
      running_sum = 0;
      errors = 0;
    endfunction

    // Accepted input transaction: advance the window and queue the result.
    function void note_input(logic [rmap_pkg::RAW_W-1:0] raw);
      int           scaled;
      int           level;
      int unsigned  smp;
      int unsigned  avg;
      rssi_result_t r;
      scaled = (int'(raw) * LEVEL_MULT) >>> LEVEL_SHIFT;
      level  = (int'(raw) >= RAW_SPLIT_V) ? scaled - HIGH_OFS : scaled + LOW_OFS;
      // negative levels still reported, but enter the window as zero
      smp    = (level < 0) ? 0 : (level << SAMPLE_SHIFT);
      running_sum = running_sum - taps[slot] + smp;
      taps[slot]  = smp;
      slot        = (slot + 1) % rmap_pkg::SAMPLE_COUNT;
      avg = running_sum / rmap_pkg::SAMPLE_COUNT;
      r.level_dbm     = rmap_pkg::level_t'(level);
      r.average_level = avg[rmap_pkg::AVG_W-1:0];
      r.percent       = rmap_pkg::PCT_W'((avg * PCT_SCALE) / FULL_RANGE);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [rmap_pkg::OUT_TDATA_W-1:0] data);
      rssi_result_t               exp_r;
      rmap_pkg::level_t           got_level;
      logic [rmap_pkg::AVG_W-1:0] got_avg;
      logic [rmap_pkg::PCT_W-1:0] got_pct;
      got_level = data[rmap_pkg::LEVEL_W-1:0];
      got_avg   = data[rmap_pkg::LEVEL_W+rmap_pkg::AVG_W-1:rmap_pkg::LEVEL_W];
      got_pct   = data[rmap_pkg::LEVEL_W+rmap_pkg::AVG_W+rmap_pkg::PCT_W-1:
                       rmap_pkg::LEVEL_W+rmap_pkg::AVG_W];
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction, tdata=%h", data);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got_level !== exp_r.level_dbm) begin
          $error("level_dbm: expected %0d, got %0d", exp_r.level_dbm, got_level);
          errors++;
        end
        if (got_avg !== exp_r.average_level) begin
          $error("average_level: expected %0d, got %0d", exp_r.average_level, got_avg);
          errors++;
        end
        if (got_pct !== exp_r.percent) begin
          $error("percent: expected %0d, got %0d", exp_r.percent, got_pct);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [rmap_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [rmap_pkg::OUT_TDATA_W-1:0] out_tdata;

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  rssi_window_scoreboard sb = new();

  rssi_moving_average_percent dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata[rmap_pkg::RAW_W-1:0]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // valid stays high across back-to-back transactions; only dropped when idling
  task automatic send_raw(input logic [rmap_pkg::RAW_W-1:0] raw);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random_burst(input int count);
    int unsigned kind;
    int          left;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(3);
      repeat ($urandom_range(24, 6)) begin
        if (left > 0) begin
          case (kind)
            0: send_raw(rmap_pkg::RAW_W'($urandom_range(255)));
            // strong signal runs
            1: send_raw(rmap_pkg::RAW_W'($urandom_range(127, 100)));
            // around the clamp
            2: send_raw(rmap_pkg::RAW_W'($urandom_range(150, RAW_SPLIT_V)));
            default: send_raw(rmap_pkg::RAW_W'($urandom_range(140, 0)));
          endcase
          left--;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, clamp edges, full window at maximum, then drop
    send_raw(8'd0);
    send_raw(8'd255);
    send_raw(8'd128);
    send_raw(8'd145);
    send_raw(8'd146);
    send_raw(8'd170);
    send_raw(8'd85);
    repeat (rmap_pkg::SAMPLE_COUNT) send_raw(8'd127);
    send_raw(8'd128);
    send_raw(8'd0);

    send_random_burst(112);
    in_idle_pct = 71;
    out_stall_pct = 0;
    send_random_burst(112);
    in_idle_pct = 0;
    out_stall_pct = 71;
    send_random_burst(112);
    in_idle_pct = 36;
    out_stall_pct = 36;
    send_random_burst(112);

    in_tvalid <= 1'b0;
    // let the monitor log the last accepted transaction first
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS rssi_moving_average_percent");
    end else begin
      $display("FAIL rssi_moving_average_percent");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL rssi_moving_average_percent");
    $finish;
  end

endmodule

// File: rssi_moving_average_percent.f
design/rmap_pkg.sv
design/rmap_level.sv
design/rmap_window.sv
design/rmap_pct.sv
design/rssi_moving_average_percent.sv
design/rmap_chk.sv
tb/sv/rssi_moving_average_percent_test.sv
